// ----- rtl/sorted_list_table_top_defines.svh -----
// ----------------------------------------------------------------------------
// sorted list table assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_TOP_DEFINES_SVH
`define SORTED_LIST_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define SLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sltab_pkg.sv -----
// ----------------------------------------------------------------------------
// sltab_pkg
// word types, operation and status codes, controller/datapath interface
// ----------------------------------------------------------------------------
package sltab_pkg;

  // operation codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_DUMP   = 2'd3;

  // status codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_FOUND    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_ELEM     = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_value;
    logic               last;
  } out_word_t;

  // read address relative to the walk index
  typedef enum logic [1:0] {
    RD_IDX_M1 = 2'd0,
    RD_IDX    = 2'd1,
    RD_IDX_P1 = 2'd2
  } rd_sel_t;

  // table write data source
  typedef enum logic {
    WR_OPERAND = 1'b0,
    WR_RDATA   = 1'b1
  } wr_sel_t;

  // result value source
  typedef enum logic [1:0] {
    VAL_OPERAND = 2'd0,
    VAL_RDATA   = 2'd1,
    VAL_ZERO    = 2'd2
  } val_sel_t;

  typedef struct packed {
    logic       load;
    logic       idx_from_count;
    logic       idx_inc;
    logic       idx_dec;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       emit;
    logic [2:0] emit_status;
    val_sel_t   val_sel;
    logic       emit_last;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic idx_zero;
    logic idx_at_count;
    logic idx_next_last;
    logic rd_less;
    logic rd_equal;
  } sts_t;

endpackage

// ----- rtl/sorted_list_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_list_table_top
// ascending table of signed 32-bit values with insert, search, delete, dump
// ----------------------------------------------------------------------------
// Usage:
//   A command word (mode, operand_value) is taken on a clock edge where start
//   is high and busy is low; busy stays high while the operation runs.
//   Results come out on response, each word valid for one cycle with strobe
//   high; there is no back-pressure. Insert, search and delete give one word;
//   dump gives one word per entry (or one empty word), last on the final one.
//   Each entry touched takes a ram read, then an evaluate/write step. busy
//   drops in the cycle the final word is shown, so the next command can
//   start then.
//   Reset empties the table (count to zero); the ram is not cleared, since
//   only counted entries are ever read.
// ----------------------------------------------------------------------------
module sorted_list_table_top import sltab_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  command,
  output logic      strobe,
  output out_word_t response
);

  ctl_t ctl;
  sts_t sts;

  // operation sequencer
  sltab_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (command.mode),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // table storage and result path
  sltab_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .command  (command),
    .ctl      (ctl),
    .sts      (sts),
    .strobe   (strobe),
    .response (response)
  );

endmodule

// ----- rtl/sltab_ram.sv -----
// ----------------------------------------------------------------------------
// sltab_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sltab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/sltab_datapath.sv -----
// ----------------------------------------------------------------------------
// sltab_datapath
// operand, walk index and entry count registers, table ram, result register
// ----------------------------------------------------------------------------
`include "sorted_list_table_top_defines.svh"

module sltab_datapath import sltab_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  command,
  input  ctl_t      ctl,
  output sts_t      sts,
  output logic      strobe,
  output out_word_t response
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] operand;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      count;
  logic [CW-1:0]      rd_idx;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        wr_data;
  logic [31:0]        rd_data;
  logic signed [31:0] result_value_next;

  // operand latch
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      operand <= command.operand_value;
    end
  end

  // walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.load) begin
      idx <= ctl.idx_from_count ? count : '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + 1'b1;
    end else if (ctl.idx_dec) begin
      idx <= idx - 1'b1;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + 1'b1;
    end else if (ctl.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  // read address select
  always_comb begin
    case (ctl.rd_sel)
      RD_IDX_M1: rd_idx = idx - 1'b1;
      RD_IDX_P1: rd_idx = idx + 1'b1;
      default:   rd_idx = idx;
    endcase
  end

  assign rd_addr = rd_idx[AW-1:0];
  assign wr_data = (ctl.wr_sel == WR_RDATA) ? rd_data : operand;

  sltab_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (idx[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // status back to the controller
  assign sts.full          = (count == CW'(DEPTH));
  assign sts.idx_zero      = (idx == '0);
  assign sts.idx_at_count  = (idx == count);
  assign sts.idx_next_last = (({1'b0, idx} + 1'b1) == {1'b0, count});
  assign sts.rd_less       = ($signed(rd_data) < operand);
  assign sts.rd_equal      = (rd_data == operand);

  // result value select
  always_comb begin
    case (ctl.val_sel)
      VAL_RDATA: result_value_next = $signed(rd_data);
      VAL_ZERO:  result_value_next = '0;
      default:   result_value_next = operand;
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      response.status       <= ctl.emit_status;
      response.result_value <= result_value_next;
      response.last         <= ctl.emit_last;
    end
  end

  // table writes stay inside the ram
  `SLT_ASSERT_NOW(a_wr_in_range, ctl.wr_en, idx < CW'(DEPTH), "table write beyond depth")
  // entry count never passes the depth
  `SLT_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(DEPTH), "entry count beyond depth")
  // every emit shows up as a strobed word in the next cycle
  `SLT_ASSERT_NEXT(a_strobe_follows, ctl.emit, strobe, "emit without strobe")

endmodule

// ----- rtl/sltab_ctrl.sv -----
// ----------------------------------------------------------------------------
// sltab_ctrl
// operation sequencer: walks the table one entry per read/evaluate pair
// ----------------------------------------------------------------------------
`include "sorted_list_table_top_defines.svh"

module sltab_ctrl import sltab_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] mode,
  input  sts_t       sts,
  output ctl_t       ctl,
  output logic       busy
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_INS_TEST  = 11'b00000000010,
    S_INS_EVAL  = 11'b00000000100,
    S_SRCH_TEST = 11'b00000001000,
    S_SRCH_EVAL = 11'b00000010000,
    S_FIND_TEST = 11'b00000100000,
    S_FIND_EVAL = 11'b00001000000,
    S_SHFT_TEST = 11'b00010000000,
    S_SHFT_EVAL = 11'b00100000000,
    S_DUMP_TEST = 11'b01000000000,
    S_DUMP_EVAL = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next      = state;
    ctl             = '0;
    ctl.rd_sel      = RD_IDX;
    ctl.wr_sel      = WR_OPERAND;
    ctl.val_sel     = VAL_OPERAND;
    ctl.emit_status = ST_DONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load           = 1'b1;
          ctl.idx_from_count = (mode == MODE_INSERT);
          case (mode)
            MODE_INSERT: state_next = S_INS_TEST;
            MODE_SEARCH: state_next = S_SRCH_TEST;
            MODE_DELETE: state_next = S_FIND_TEST;
            MODE_DUMP:   state_next = S_DUMP_TEST;
            default:     state_next = S_IDLE;
          endcase
        end
      end

      // insert walks down from the top, moving larger and equal entries up by one
      S_INS_TEST: begin
        if (sts.full) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_FULL;
          ctl.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else if (sts.idx_zero) begin
          ctl.wr_en     = 1'b1;
          ctl.cnt_inc   = 1'b1;
          ctl.emit      = 1'b1;
          ctl.emit_last = 1'b1;
          state_next    = S_IDLE;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_IDX_M1;
          state_next = S_INS_EVAL;
        end
      end
      S_INS_EVAL: begin
        if (sts.rd_less) begin
          ctl.wr_en     = 1'b1;
          ctl.cnt_inc   = 1'b1;
          ctl.emit      = 1'b1;
          ctl.emit_last = 1'b1;
          state_next    = S_IDLE;
        end else begin
          ctl.wr_en   = 1'b1;
          ctl.wr_sel  = WR_RDATA;
          ctl.idx_dec = 1'b1;
          state_next  = S_INS_TEST;
        end
      end

      // search scans up from the bottom
      S_SRCH_TEST: begin
        if (sts.idx_at_count) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_NOTFOUND;
          ctl.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          ctl.rd_en  = 1'b1;
          state_next = S_SRCH_EVAL;
        end
      end
      S_SRCH_EVAL: begin
        if (sts.rd_equal) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_FOUND;
          ctl.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_SRCH_TEST;
        end
      end

      // delete: find the first equal entry, then pull later entries down
      S_FIND_TEST: begin
        if (sts.idx_at_count) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_NOTFOUND;
          ctl.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          ctl.rd_en  = 1'b1;
          state_next = S_FIND_EVAL;
        end
      end
      S_FIND_EVAL: begin
        if (sts.rd_equal) begin
          state_next = S_SHFT_TEST;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_FIND_TEST;
        end
      end
      S_SHFT_TEST: begin
        if (sts.idx_next_last) begin
          ctl.cnt_dec   = 1'b1;
          ctl.emit      = 1'b1;
          ctl.emit_last = 1'b1;
          state_next    = S_IDLE;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_IDX_P1;
          state_next = S_SHFT_EVAL;
        end
      end
      S_SHFT_EVAL: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_sel  = WR_RDATA;
        ctl.idx_inc = 1'b1;
        state_next  = S_SHFT_TEST;
      end

      // dump streams entries in order, one word per read
      S_DUMP_TEST: begin
        if (sts.idx_at_count) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_EMPTY;
          ctl.val_sel     = VAL_ZERO;
          ctl.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          ctl.rd_en  = 1'b1;
          state_next = S_DUMP_EVAL;
        end
      end
      S_DUMP_EVAL: begin
        ctl.emit        = 1'b1;
        ctl.emit_status = ST_ELEM;
        ctl.val_sel     = VAL_RDATA;
        ctl.emit_last   = sts.idx_next_last;
        if (sts.idx_next_last) begin
          state_next = S_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_DUMP_TEST;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // no table access while idle
  `SLT_ASSERT_NOW(a_idle_quiet, state == S_IDLE,
                  !(ctl.wr_en || ctl.rd_en || ctl.emit), "table access while idle")
  // the final word of an operation returns the sequencer to idle
  `SLT_ASSERT_NEXT(a_last_to_idle, ctl.emit && ctl.emit_last, state == S_IDLE,
                   "no idle after last word")
  // a word that is not last keeps the operation running
  `SLT_ASSERT_NEXT(a_more_busy, ctl.emit && !ctl.emit_last, state != S_IDLE,
                   "idle before last word")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted list table testbench
// drives insert, search, delete and dump words through the start/busy port,
// keeps a shadow copy of the ordered table to work out every response word,
// and checks each strobed word in order against that prediction
// ----------------------------------------------------------------------------
module tb_top;
  import sltab_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int PHASE_ITEMS = 81;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  command = '0;
  logic      strobe;
  out_word_t response;

  // words waiting to be sent and response words still owed
  in_word_t  pending_words[$];
  out_word_t expected_results[$];

  // shadow of the ordered table
  logic signed [31:0] table_vals[TABLE_DEPTH];
  int table_count = 0;

  int idle_pct = 0;
  int fail_count = 0;
  int items_sent = 0;
  int words_checked = 0;
  int full_hits = 0;
  int empty_dumps = 0;
  int found_hits = 0;
  int delete_hits = 0;

  sorted_list_table_top #(.DEPTH(TABLE_DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .strobe   (strobe),
    .response (response)
  );

  always #6 clk = ~clk;

  // apply one accepted command to the shadow table, queue its response words
  task automatic apply_table_op(input in_word_t w);
    int pos;
    int i;
    out_word_t r;
    r.status = ST_DONE;
    r.result_value = w.operand_value;
    r.last = 1'b1;
    case (w.mode)
      MODE_INSERT: begin
        if (table_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          pos = 0;
          // equal values land in front of existing equal entries
          while (pos < table_count && table_vals[pos] < w.operand_value) pos++;
          for (i = table_count; i > pos; i--) table_vals[i] = table_vals[i-1];
          table_vals[pos] = w.operand_value;
          table_count++;
        end
        expected_results.push_back(r);
      end
      MODE_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < table_count; i++) begin
          if (table_vals[i] == w.operand_value) r.status = ST_FOUND;
        end
        if (r.status == ST_FOUND) found_hits++;
        expected_results.push_back(r);
      end
      MODE_DELETE: begin
        pos = 0;
        while (pos < table_count && table_vals[pos] != w.operand_value) pos++;
        if (pos >= table_count) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (i = pos; i + 1 < table_count; i++) table_vals[i] = table_vals[i+1];
          table_count--;
          delete_hits++;
        end
        expected_results.push_back(r);
      end
      default: begin
        if (table_count == 0) begin
          r.status = ST_EMPTY;
          r.result_value = '0;
          empty_dumps++;
          expected_results.push_back(r);
        end else begin
          for (i = 0; i < table_count; i++) begin
            r.status = ST_ELEM;
            r.result_value = table_vals[i];
            r.last = (i + 1 == table_count);
            expected_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic push_word(input logic [1:0] mode, input logic signed [31:0] value);
    in_word_t w;
    w.mode = mode;
    w.operand_value = value;
    pending_words.push_back(w);
  endtask

  // mostly a small pool so duplicates and hits are common, some extremes and noise
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $signed($urandom_range(0, 11)) - 6;
    if (r < 78) return 32'sh8000_0000;
    if (r < 86) return 32'sh7fff_ffff;
    return $signed($urandom());
  endfunction

  // hold off until every queued word is sent and every response has arrived
  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || start || busy || expected_results.size() != 0);
  endtask

  // driver: present the oldest pending word, hold it until taken
  always @(posedge clk) begin : drive_proc
    logic taken;
    if (rst) begin
      start <= 1'b0;
      command <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        apply_table_op(command);
        void'(pending_words.pop_front());
        items_sent++;
      end
      if (!(start && !taken)) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          command <= pending_words[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed word must match the oldest expectation
  always @(posedge clk) begin : check_proc
    out_word_t want;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        $error("response word with none expected: status %0d value %0d last %0b",
               response.status, response.result_value, response.last);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        words_checked++;
        if (response.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, response.status);
          fail_count++;
        end
        if (response.result_value !== want.result_value) begin
          $error("result_value expected %0d got %0d", want.result_value,
                 response.result_value);
          fail_count++;
        end
        if (response.last !== want.last) begin
          $error("last expected %0b got %0b", want.last, response.last);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin : stim_proc
    int phase;
    int n;
    int k;
    logic [1:0] mode;
    int insert_pcts[4];
    int idle_pcts[4];
    insert_pcts = '{55, 30, 50, 40};
    idle_pcts = '{0, 52, 0, 17};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table cases, extremes, hits and misses, fill past full
    push_word(MODE_DUMP, 32'sd7);
    push_word(MODE_SEARCH, 32'sd0);
    push_word(MODE_DELETE, 32'sd0);
    push_word(MODE_INSERT, 32'sh8000_0000);
    push_word(MODE_INSERT, 32'sh7fff_ffff);
    push_word(MODE_INSERT, 32'sd0);
    push_word(MODE_INSERT, -32'sd1);
    push_word(MODE_INSERT, 32'sd1);
    push_word(MODE_INSERT, 32'sd0);
    push_word(MODE_SEARCH, 32'sh8000_0000);
    push_word(MODE_SEARCH, 32'sd5);
    push_word(MODE_DUMP, 32'sh7fff_ffff);
    for (k = 0; k < 10; k++) push_word(MODE_INSERT, $signed(32'h5555_5555 ^ (k << 28)));
    push_word(MODE_INSERT, 32'sd3);
    push_word(MODE_DUMP, '0);
    push_word(MODE_DELETE, 32'sh7fff_ffff);
    push_word(MODE_DELETE, 32'sd12345);
    drain();

    // random phases, each with its own sender idling and operation mix
    for (phase = 0; phase < 4; phase++) begin
      idle_pct = idle_pcts[phase];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < insert_pcts[phase]) begin
          mode = MODE_INSERT;
        end else begin
          k = $urandom_range(0, 99);
          mode = (k < 35) ? MODE_SEARCH : (k < 85) ? MODE_DELETE : MODE_DUMP;
        end
        push_word(mode, pick_value());
      end
      drain();
    end

    repeat (40) @(negedge clk);
    $display("sent %0d command words, checked %0d response words", items_sent,
             words_checked);
    $display("full rejects %0d, empty dumps %0d, search hits %0d, deletes %0d",
             full_hits, empty_dumps, found_hits, delete_hits);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin : limit_proc
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
